// ----- hdl/sptw_pkg.sv -----
package sptw_pkg;

    localparam logic CMD_REQUEST  = 1'b0;
    localparam logic CMD_RESPONSE = 1'b1;

    localparam logic OUT_MEM_READ = 1'b0;
    localparam logic OUT_DONE     = 1'b1;

    localparam logic [2:0] KIND_CODE        = 3'd0;
    localparam logic [2:0] KIND_DATA_READ   = 3'd1;
    localparam logic [2:0] KIND_DATA_WRITE  = 3'd2;
    localparam logic [2:0] KIND_STACK_READ  = 3'd3;
    localparam logic [2:0] KIND_STACK_WRITE = 3'd4;

    localparam logic [2:0] FAULT_NONE    = 3'd0;
    localparam logic [2:0] FAULT_PROT    = 3'd1;
    localparam logic [2:0] FAULT_ABSENT  = 3'd2;
    localparam logic [2:0] FAULT_CODE    = 3'd3;
    localparam logic [2:0] FAULT_DATA    = 3'd4;
    localparam logic [2:0] FAULT_PAGE    = 3'd5;
    localparam logic [2:0] FAULT_DIR     = 3'd6;

    localparam logic [2:0] REG_MODE        = 3'd0;
    localparam logic [2:0] REG_DIR_BASE    = 3'd1;
    localparam logic [2:0] REG_DATA_BASE   = 3'd2;
    localparam logic [2:0] REG_DATA_LIMIT  = 3'd3;
    localparam logic [2:0] REG_DATA_FLAGS  = 3'd4;
    localparam logic [2:0] REG_STACK_BASE  = 3'd5;
    localparam logic [2:0] REG_STACK_LIMIT = 3'd6;
    localparam logic [2:0] REG_STACK_FLAGS = 3'd7;

    localparam logic [1:0] PHASE_IDLE = 2'd0;
    localparam logic [1:0] PHASE_DIR  = 2'd1;
    localparam logic [1:0] PHASE_PAGE = 2'd2;

    localparam int MODE_SEG    = 0;
    localparam int MODE_PAGING = 1;
    localparam int MODE_PM     = 2;
    localparam int MODE_BYPASS = 3;

    localparam int SEG_PRESENT = 0;
    localparam int SEG_PROTECT = 1;
    localparam int SEG_READ    = 2;
    localparam int SEG_WRITE   = 3;
    localparam int SEG_EXEC    = 4;

    localparam logic [31:0] PAGE_FRAME_MASK  = 32'hFFFF_F000;
    localparam logic [31:0] PAGE_OFFSET_MASK = 32'h0000_0FFF;

    typedef struct packed {
        logic        kind;
        logic [31:0] addr;
        logic [2:0]  fault;
    } result_t;

endpackage

// ----- hdl/segment_page_translation_walker.sv -----
// An accepted transaction is captured in the input register, and its result then in the output register.
// Throughput: one transaction per cycle; the input and output registers advance together
//   whenever the output register is empty or being drained.
// A memory response that arrives with no walk in progress is consumed without a result.
// Reset (rst_n, asynchronous, active low) clears all configuration registers, the walk
//   phase, the held address and kind, and both stage valid flags.
module segment_page_translation_walker
    import sptw_pkg::*;
#(
    parameter int PAGE_VALID_BIT   = 0,
    parameter int PAGE_PROTECT_BIT = 1,
    parameter int PAGE_READ_BIT    = 2,
    parameter int PAGE_WRITE_BIT   = 3,
    parameter int PAGE_EXEC_BIT    = 4
)
(
    input  logic        clk,
    input  logic        rst_n,

    input  logic        in_valid,
    output logic        in_ready,
    input  logic        cmd,
    input  logic [31:0] virt_addr,
    input  logic [2:0]  access_kind,
    input  logic [31:0] read_word,

    output logic        out_valid,
    input  logic        out_ready,
    output logic        out_kind,
    output logic [31:0] out_addr,
    output logic [2:0]  fault,

    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [31:0] cfg_data
);

    logic [3:0]  mode_reg;
    logic [31:0] dir_base_reg;
    logic [31:0] data_base_reg;
    logic [31:0] data_limit_reg;
    logic [4:0]  data_flags_reg;
    logic [31:0] stack_base_reg;
    logic [31:0] stack_limit_reg;
    logic [4:0]  stack_flags_reg;

    logic        s1_valid_reg;
    logic        s1_cmd_reg;
    logic [31:0] s1_addr_reg;
    logic [2:0]  s1_kind_reg;
    logic [31:0] s1_word_reg;

    logic [1:0]  phase_reg;
    logic [1:0]  phase_next;
    logic [31:0] held_addr_reg;
    logic [31:0] held_addr_next;
    logic [2:0]  held_kind_reg;
    logic [2:0]  held_kind_next;

    logic        out_valid_reg;
    result_t     out_reg;
    result_t     res;
    logic        produce;

    logic        out_free;
    logic        s1_advance;

    logic        pm;
    logic        stack_sel;
    logic [31:0] seg_base;
    logic [31:0] seg_limit;
    logic [4:0]  seg_flags;
    logic        seg_right;
    logic [31:0] seg_sum;
    logic [31:0] lin_addr;
    logic [2:0]  denied;
    logic [2:0]  held_denied;
    logic        page_right;

    assign cfg_ready  = 1'b1;
    assign out_free   = !out_valid_reg || out_ready;
    assign s1_advance = s1_valid_reg && out_free;
    assign in_ready   = !s1_valid_reg || s1_advance;

    assign out_valid = out_valid_reg;
    assign out_kind  = out_reg.kind;
    assign out_addr  = out_reg.addr;
    assign fault     = out_reg.fault;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg        <= '0;
            dir_base_reg    <= '0;
            data_base_reg   <= '0;
            data_limit_reg  <= '0;
            data_flags_reg  <= '0;
            stack_base_reg  <= '0;
            stack_limit_reg <= '0;
            stack_flags_reg <= '0;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_MODE:        mode_reg        <= cfg_data[3:0];
                REG_DIR_BASE:    dir_base_reg    <= cfg_data;
                REG_DATA_BASE:   data_base_reg   <= cfg_data;
                REG_DATA_LIMIT:  data_limit_reg  <= cfg_data;
                REG_DATA_FLAGS:  data_flags_reg  <= cfg_data[4:0];
                REG_STACK_BASE:  stack_base_reg  <= cfg_data;
                REG_STACK_LIMIT: stack_limit_reg <= cfg_data;
                REG_STACK_FLAGS: stack_flags_reg <= cfg_data[4:0];
                default:         mode_reg        <= mode_reg;
            endcase
        end
    end

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            s1_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            s1_cmd_reg  <= cmd;
            s1_addr_reg <= virt_addr;
            s1_kind_reg <= access_kind;
            s1_word_reg <= read_word;
        end
    end

    // segment step
    always_comb
    begin
        pm        = mode_reg[MODE_PM];
        stack_sel = (s1_kind_reg == KIND_CODE) || (s1_kind_reg == KIND_STACK_READ)
                    || (s1_kind_reg == KIND_STACK_WRITE);
        seg_base  = stack_sel ? stack_base_reg  : data_base_reg;
        seg_limit = stack_sel ? stack_limit_reg : data_limit_reg;
        seg_flags = stack_sel ? stack_flags_reg : data_flags_reg;
        seg_sum   = s1_addr_reg + seg_base;
        denied    = (s1_kind_reg == KIND_CODE) ? FAULT_CODE : FAULT_DATA;
        unique case (s1_kind_reg)
            KIND_CODE:                        seg_right = seg_flags[SEG_EXEC];
            KIND_DATA_READ, KIND_STACK_READ:  seg_right = seg_flags[SEG_READ];
            default:                          seg_right = seg_flags[SEG_WRITE];
        endcase
        lin_addr  = mode_reg[MODE_SEG] ? seg_sum : s1_addr_reg;

        held_denied = (held_kind_reg == KIND_CODE) ? FAULT_CODE : FAULT_DATA;
        unique case (held_kind_reg)
            KIND_CODE:                        page_right = s1_word_reg[PAGE_EXEC_BIT];
            KIND_DATA_READ, KIND_STACK_READ:  page_right = s1_word_reg[PAGE_READ_BIT];
            default:                          page_right = s1_word_reg[PAGE_WRITE_BIT];
        endcase
    end

    // translation step
    always_comb
    begin
        phase_next     = phase_reg;
        held_addr_next = held_addr_reg;
        held_kind_next = held_kind_reg;
        produce        = 1'b0;
        res.kind       = OUT_DONE;
        res.addr       = '0;
        res.fault      = FAULT_NONE;

        if (s1_cmd_reg == CMD_REQUEST)
        begin
            phase_next = PHASE_IDLE;
            produce    = 1'b1;
            if (s1_kind_reg > KIND_STACK_WRITE)
            begin
                res.fault = FAULT_DATA;
            end
            else if (s1_kind_reg == KIND_CODE && mode_reg[MODE_BYPASS])
            begin
                res.addr = s1_addr_reg;
            end
            else if (mode_reg[MODE_SEG] && !seg_flags[SEG_PRESENT])
            begin
                res.fault = FAULT_ABSENT;
            end
            else if (mode_reg[MODE_SEG] && seg_flags[SEG_PROTECT] && pm)
            begin
                res.fault = FAULT_PROT;
            end
            else if (mode_reg[MODE_SEG]
                     && (!seg_right || seg_sum >= seg_limit || seg_sum < seg_base))
            begin
                res.fault = denied;
            end
            else if (!mode_reg[MODE_PAGING])
            begin
                res.addr = lin_addr;
            end
            else
            begin
                held_addr_next = lin_addr;
                held_kind_next = s1_kind_reg;
                phase_next     = PHASE_DIR;
                res.kind       = OUT_MEM_READ;
                res.addr       = dir_base_reg + {20'd0, lin_addr[31:22], 2'b00};
            end
        end
        else
        begin
            phase_next = PHASE_IDLE;
            unique case (phase_reg)
                PHASE_DIR:
                begin
                    produce = 1'b1;
                    if (s1_word_reg == '0)
                    begin
                        res.fault = FAULT_DIR;
                    end
                    else
                    begin
                        phase_next = PHASE_PAGE;
                        res.kind   = OUT_MEM_READ;
                        res.addr   = s1_word_reg + {20'd0, held_addr_reg[21:12], 2'b00};
                    end
                end
                PHASE_PAGE:
                begin
                    produce = 1'b1;
                    if (!s1_word_reg[PAGE_VALID_BIT])
                    begin
                        res.fault = FAULT_PAGE;
                    end
                    else if (s1_word_reg[PAGE_PROTECT_BIT] && pm)
                    begin
                        res.fault = FAULT_PROT;
                    end
                    else if (!page_right)
                    begin
                        res.fault = held_denied;
                    end
                    else
                    begin
                        res.addr = (s1_word_reg & PAGE_FRAME_MASK)
                                   | (held_addr_reg & PAGE_OFFSET_MASK);
                    end
                end
                default:
                begin
                    produce = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PHASE_IDLE;
            held_addr_reg <= '0;
            held_kind_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s1_advance)
            begin
                phase_reg     <= phase_next;
                held_addr_reg <= held_addr_next;
                held_kind_reg <= held_kind_next;
            end
            if (out_free)
            begin
                out_valid_reg <= s1_advance && produce;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_advance && produce)
        begin
            out_reg <= res;
        end
    end

endmodule

// ----- hdl/sptw_checker.sv -----
module sptw_checker
    import sptw_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        out_valid,
    input logic        out_ready,
    input logic        out_kind,
    input logic [31:0] out_addr,
    input logic [2:0]  fault
);

    a_req_no_fault: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_kind == OUT_MEM_READ |-> fault == FAULT_NONE)
        else $error("memory read request carries a fault");

    a_fault_zero_addr: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && fault != FAULT_NONE |-> out_addr == '0)
        else $error("faulted translation with nonzero address");

    a_fault_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> fault != 3'd7)
        else $error("undefined fault code");

    a_page_fault_done: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (fault == FAULT_PAGE || fault == FAULT_DIR) |-> out_kind == OUT_DONE)
        else $error("walk fault not reported as finished");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_addr) && $stable(fault))
        else $error("stalled result changed");

endmodule

bind segment_page_translation_walker sptw_checker u_sptw_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_kind  (out_kind),
    .out_addr  (out_addr),
    .fault     (fault)
);

// ----- tb/translation_checker.sv -----
`timescale 1ns / 1ps

module translation_checker
    import sptw_pkg::*;
#(
    parameter int PG_VALID   = 0,
    parameter int PG_PROTECT = 1,
    parameter int PG_READ    = 2,
    parameter int PG_WRITE   = 3,
    parameter int PG_EXEC    = 4
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic        in_ready,
    input  logic        cmd,
    input  logic [31:0] virt_addr,
    input  logic [2:0]  access_kind,
    input  logic [31:0] read_word,
    input  logic        out_valid,
    input  logic        out_ready,
    input  logic        out_kind,
    input  logic [31:0] out_addr,
    input  logic [2:0]  fault,
    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [31:0] cfg_data,
    output int          failures,
    output int          pending,
    output int          predicted
);

    logic [3:0]  mode_q;
    logic [31:0] pdir_base;
    logic [31:0] dseg_base;
    logic [31:0] dseg_limit;
    logic [4:0]  dseg_flags;
    logic [31:0] sseg_base;
    logic [31:0] sseg_limit;
    logic [4:0]  sseg_flags;

    logic [1:0]  phase_q;
    logic [31:0] latched_addr;
    logic [2:0]  latched_kind;

    result_t     expected_walk_outputs [$];

    function automatic int right_bit(input logic [2:0] k, input int exec_bit, read_bit,
                                     write_bit);
        if (k == KIND_CODE)
            return exec_bit;
        if (k == KIND_DATA_READ || k == KIND_STACK_READ)
            return read_bit;
        return write_bit;
    endfunction

    function automatic logic [2:0] denial(input logic [2:0] k);
        return (k == KIND_CODE) ? FAULT_CODE : FAULT_DATA;
    endfunction

    // Returns 1 when the transaction produces an output; updates the walk state.
    function automatic bit translate_item(input logic c, input logic [31:0] va,
                                          input logic [2:0] ak, input logic [31:0] rw,
                                          output result_t res);
        logic        pm;
        logic        use_stack;
        logic [31:0] seg_base;
        logic [31:0] seg_limit;
        logic [4:0]  seg_flags;
        logic [31:0] sum;
        pm  = mode_q[MODE_PM];
        res = '{kind: OUT_DONE, addr: 32'd0, fault: FAULT_NONE};
        if (c == CMD_REQUEST)
        begin
            phase_q = PHASE_IDLE;
            if (ak > KIND_STACK_WRITE)
            begin
                res.fault = FAULT_DATA;
                return 1'b1;
            end
            if (ak == KIND_CODE && mode_q[MODE_BYPASS])
            begin
                res.addr = va;
                return 1'b1;
            end
            sum = va;
            if (mode_q[MODE_SEG])
            begin
                use_stack = (ak == KIND_CODE || ak == KIND_STACK_READ ||
                             ak == KIND_STACK_WRITE);
                seg_base  = use_stack ? sseg_base  : dseg_base;
                seg_limit = use_stack ? sseg_limit : dseg_limit;
                seg_flags = use_stack ? sseg_flags : dseg_flags;
                if (!seg_flags[SEG_PRESENT])
                begin
                    res.fault = FAULT_ABSENT;
                    return 1'b1;
                end
                if (seg_flags[SEG_PROTECT] && pm)
                begin
                    res.fault = FAULT_PROT;
                    return 1'b1;
                end
                sum = va + seg_base;
                if (!seg_flags[right_bit(ak, SEG_EXEC, SEG_READ, SEG_WRITE)] ||
                    sum >= seg_limit || sum < seg_base)
                begin
                    res.fault = denial(ak);
                    return 1'b1;
                end
            end
            if (!mode_q[MODE_PAGING])
            begin
                res.addr = sum;
                return 1'b1;
            end
            latched_addr = sum;
            latched_kind = ak;
            phase_q      = PHASE_DIR;
            res.kind     = OUT_MEM_READ;
            res.addr     = pdir_base + {20'd0, sum[31:22], 2'b00};
            return 1'b1;
        end
        if (phase_q == PHASE_DIR)
        begin
            if (rw == 32'd0)
            begin
                phase_q   = PHASE_IDLE;
                res.fault = FAULT_DIR;
                return 1'b1;
            end
            phase_q  = PHASE_PAGE;
            res.kind = OUT_MEM_READ;
            res.addr = rw + {20'd0, latched_addr[21:12], 2'b00};
            return 1'b1;
        end
        if (phase_q == PHASE_PAGE)
        begin
            phase_q = PHASE_IDLE;
            if (!rw[PG_VALID])
                res.fault = FAULT_PAGE;
            else if (rw[PG_PROTECT] && pm)
                res.fault = FAULT_PROT;
            else if (!rw[right_bit(latched_kind, PG_EXEC, PG_READ, PG_WRITE)])
                res.fault = denial(latched_kind);
            else
                res.addr = (rw & PAGE_FRAME_MASK) | (latched_addr & PAGE_OFFSET_MASK);
            return 1'b1;
        end
        phase_q = PHASE_IDLE;
        return 1'b0;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        result_t want;
        result_t seen;
        if (!rst_n)
        begin
            mode_q       = '0;
            pdir_base    = '0;
            dseg_base    = '0;
            dseg_limit   = '0;
            dseg_flags   = '0;
            sseg_base    = '0;
            sseg_limit   = '0;
            sseg_flags   = '0;
            phase_q      = PHASE_IDLE;
            latched_addr = '0;
            latched_kind = KIND_CODE;
            expected_walk_outputs.delete();
            pending      = 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    REG_MODE:        mode_q     = cfg_data[3:0];
                    REG_DIR_BASE:    pdir_base  = cfg_data;
                    REG_DATA_BASE:   dseg_base  = cfg_data;
                    REG_DATA_LIMIT:  dseg_limit = cfg_data;
                    REG_DATA_FLAGS:  dseg_flags = cfg_data[4:0];
                    REG_STACK_BASE:  sseg_base  = cfg_data;
                    REG_STACK_LIMIT: sseg_limit = cfg_data;
                    REG_STACK_FLAGS: sseg_flags = cfg_data[4:0];
                endcase
            end
            if (in_valid && in_ready)
            begin
                if (translate_item(cmd, virt_addr, access_kind, read_word, want))
                begin
                    expected_walk_outputs.push_back(want);
                    predicted++;
                end
            end
            if (out_valid && out_ready)
            begin
                seen = '{kind: out_kind, addr: out_addr, fault: fault};
                if (expected_walk_outputs.size() == 0)
                begin
                    $display("%0t: unexpected transaction kind %0d addr %h fault %0d",
                             $time, seen.kind, seen.addr, seen.fault);
                    failures++;
                end
                else
                begin
                    want = expected_walk_outputs.pop_front();
                    if (seen.kind !== want.kind)
                    begin
                        $display("%0t: out_kind expected %0d actual %0d",
                                 $time, want.kind, seen.kind);
                        failures++;
                    end
                    if (seen.addr !== want.addr)
                    begin
                        $display("%0t: out_addr expected %h actual %h",
                                 $time, want.addr, seen.addr);
                        failures++;
                    end
                    if (seen.fault !== want.fault)
                    begin
                        $display("%0t: fault expected %0d actual %0d",
                                 $time, want.fault, seen.fault);
                        failures++;
                    end
                end
            end
            pending = expected_walk_outputs.size();
        end
    end

endmodule

// ----- tb/tb_segment_page_translation_walker.sv -----
`timescale 1ns / 1ps

module tb_segment_page_translation_walker;
    import sptw_pkg::*;

    localparam int RANDOM_ITEMS = 1900;
    localparam int LONG_HOLD    = 300;
    localparam int SETTLE       = 8;
    localparam int TIMEOUT_NS   = 1_600_000;

    localparam int PG_VALID   = 0;
    localparam int PG_PROTECT = 1;
    localparam int PG_READ    = 2;
    localparam int PG_WRITE   = 3;
    localparam int PG_EXEC    = 4;

    localparam logic [2:0] KIND_UNDEF_FIRST = 3'd5;
    localparam logic [2:0] KIND_UNDEF_LAST  = 3'd7;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic        cmd;
    logic [31:0] virt_addr;
    logic [2:0]  access_kind;
    logic [31:0] read_word;
    logic        out_valid;
    logic        out_ready;
    logic        out_kind;
    logic [31:0] out_addr;
    logic [2:0]  fault;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [2:0]  cfg_index;
    logic [31:0] cfg_data;

    int failures;
    int pending;
    int predicted;

    bit gaps_on;
    bit sink_stalls;
    bit hold_req;

    always
    begin
        clk = 1'b0;
        #1;
        clk = 1'b1;
        #1;
    end

    segment_page_translation_walker DUT (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .cmd         (cmd),
        .virt_addr   (virt_addr),
        .access_kind (access_kind),
        .read_word   (read_word),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .out_kind    (out_kind),
        .out_addr    (out_addr),
        .fault       (fault),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data)
    );

    translation_checker u_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .cmd         (cmd),
        .virt_addr   (virt_addr),
        .access_kind (access_kind),
        .read_word   (read_word),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .out_kind    (out_kind),
        .out_addr    (out_addr),
        .fault       (fault),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .failures    (failures),
        .pending     (pending),
        .predicted   (predicted)
    );

    function automatic int pause_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 65)
            return 0;
        if (r < 93)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function automatic logic [31:0] pick_addr();
        case ($urandom_range(0, 3))
            0:       return $urandom_range(0, 32'hFFFF);
            1:       return 32'hFFFF_FFFF - $urandom_range(0, 255);
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [31:0] dir_entry();
        return ($urandom_range(0, 7) == 0) ? 32'd0 : $urandom;
    endfunction

    function automatic logic [31:0] page_entry();
        logic [31:0] w;
        w = $urandom;
        if ($urandom_range(0, 99) < 80)
            w[PG_VALID] = 1'b1;
        if ($urandom_range(0, 99) < 60)
            w[PG_PROTECT] = 1'b0;
        if ($urandom_range(0, 99) < 60)
        begin
            w[PG_READ]  = 1'b1;
            w[PG_WRITE] = 1'b1;
            w[PG_EXEC]  = 1'b1;
        end
        return w;
    endfunction

    function automatic logic [31:0] seg_flags();
        logic [31:0] f;
        f = $urandom_range(0, 31);
        if ($urandom_range(0, 99) < 85)
            f[SEG_PRESENT] = 1'b1;
        if ($urandom_range(0, 99) < 70)
            f[SEG_PROTECT] = 1'b0;
        return f;
    endfunction

    function automatic logic [31:0] seg_base();
        case ($urandom_range(0, 3))
            0:       return 32'd0;
            1:       return $urandom;
            default: return $urandom_range(0, 32'hFFFF);
        endcase
    endfunction

    function automatic logic [31:0] seg_limit();
        case ($urandom_range(0, 2))
            0:       return 32'hFFFF_FFFF;
            1:       return $urandom;
            default: return 32'h8000_0000 + $urandom_range(0, 32'h7FFF_FFFF);
        endcase
    endfunction

    task automatic send(input logic c, input logic [31:0] va, input logic [2:0] k,
                        input logic [31:0] w);
        int gap;
        gap = gaps_on ? pause_len() : 0;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid    <= 1'b1;
        cmd         <= c;
        virt_addr   <= va;
        access_kind <= k;
        read_word   <= w;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        @(negedge clk);
    endtask

    task automatic request(input logic [31:0] va, input logic [2:0] k);
        send(CMD_REQUEST, va, k, $urandom);
    endtask

    task automatic respond(input logic [31:0] w);
        send(CMD_RESPONSE, $urandom, 3'($urandom_range(0, 7)), w);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (pending != 0) @(negedge clk);
        repeat (SETTLE) @(negedge clk);
    endtask

    task automatic configure(input logic [31:0] mode, dir, dbase, dlimit, dflags,
                             sbase, slimit, sflags);
        logic [31:0] vals [8];
        drain();
        vals[REG_MODE]        = mode;
        vals[REG_DIR_BASE]    = dir;
        vals[REG_DATA_BASE]   = dbase;
        vals[REG_DATA_LIMIT]  = dlimit;
        vals[REG_DATA_FLAGS]  = dflags;
        vals[REG_STACK_BASE]  = sbase;
        vals[REG_STACK_LIMIT] = slimit;
        vals[REG_STACK_FLAGS] = sflags;
        for (int i = 0; i < 8; i++)
        begin
            cfg_valid <= 1'b1;
            cfg_index <= 3'(i);
            cfg_data  <= vals[i];
            @(posedge clk);
            while (!cfg_ready) @(posedge clk);
            @(negedge clk);
        end
        cfg_valid <= 1'b0;
    endtask

    task automatic random_settings(input int idx);
        logic [31:0] m;
        if (idx == 0)
            configure(32'hF, '1, '1, '1, 32'h1F, '1, '1, 32'h1F);
        else if (idx == 1)
            configure('0, '0, '0, '0, '0, '0, '0, '0);
        else if (idx == 2)
            configure(32'hF, '0, '0, '0, '0, '0, '0, '0);
        else if ($urandom_range(0, 99) < 25)
            configure($urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                      $urandom);
        else
        begin
            m = $urandom_range(0, 15);
            if ($urandom_range(0, 99) < 80)
                m[MODE_PAGING] = 1'b1;
            if ($urandom_range(0, 99) < 80)
                m[MODE_SEG] = 1'b1;
            configure(m, $urandom, seg_base(), seg_limit(), seg_flags(), seg_base(),
                      seg_limit(), seg_flags());
        end
    endtask

    task automatic walk_sequence();
        logic [2:0] k;
        int         depth;
        if ($urandom_range(0, 99) < 92)
            k = 3'($urandom_range(KIND_CODE, KIND_STACK_WRITE));
        else
            k = 3'($urandom_range(KIND_UNDEF_FIRST, KIND_UNDEF_LAST));
        request(pick_addr(), k);
        depth = $urandom_range(0, 99);
        if (depth < 90)
            respond(dir_entry());
        if (depth < 80)
            respond(page_entry());
        if (depth >= 97)
            respond($urandom);
    endtask

    // sink side: random stalls plus one long hold on request
    initial
    begin
        int stall_left;
        out_ready  = 1'b0;
        stall_left = 0;
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                out_ready <= 1'b0;
                repeat (LONG_HOLD - 1) @(negedge clk);
                hold_req = 1'b0;
            end
            else if (stall_left > 0)
            begin
                out_ready <= 1'b0;
                stall_left--;
            end
            else
            begin
                out_ready <= 1'b1;
                if (sink_stalls)
                    stall_left = pause_len();
            end
        end
    end

    initial
    begin
        int goal;
        int phase_goal;
        int phase_idx;
        rst_n       = 1'b0;
        in_valid    = 1'b0;
        cmd         = CMD_REQUEST;
        virt_addr   = '0;
        access_kind = KIND_CODE;
        read_word   = '0;
        cfg_valid   = 1'b0;
        cfg_index   = REG_MODE;
        cfg_data    = '0;
        gaps_on     = 1'b0;
        sink_stalls = 1'b0;
        hold_req    = 1'b0;
        repeat (10) @(negedge clk);
        rst_n = 1'b1;

        // reset settings: no translation, undefined kinds, stray response
        request(32'h0000_0000, KIND_CODE);
        request(32'hFFFF_FFFF, KIND_STACK_WRITE);
        request($urandom, KIND_UNDEF_FIRST);
        request($urandom, KIND_UNDEF_LAST);
        respond(32'hFFFF_FFFF);

        configure((32'd1 << MODE_SEG) | (32'd1 << MODE_PAGING), 32'h0000_1000,
                  32'h0000_0100, 32'h8000_0000,
                  (32'd1 << SEG_PRESENT) | (32'd1 << SEG_READ) | (32'd1 << SEG_WRITE),
                  32'h0, 32'hFFFF_FFFF, 32'h1D);
        request(32'h0040_2345, KIND_DATA_READ);
        respond(32'h0020_0000);
        respond(32'hABCD_E000 | (32'd1 << PG_VALID) | (32'd1 << PG_READ));
        request(32'h0000_1000, KIND_DATA_WRITE);
        respond(32'h0030_0000);
        respond(32'h1234_5000 | (32'd1 << PG_VALID) | (32'd1 << PG_READ));
        request(32'h0000_2000, KIND_CODE);
        respond(32'h0);
        request(32'h0000_3000, KIND_STACK_READ);
        respond(32'h0040_0000);
        respond(32'hFFFF_FFFE);
        request(32'h7FFF_FFFF, KIND_DATA_READ);
        request(32'h0000_4000, KIND_CODE);
        respond(32'h0050_0000);
        request(32'h0000_5000, KIND_STACK_WRITE);
        respond(32'h0060_0000);
        respond(32'h8765_4000 | (32'd1 << PG_VALID) | (32'd1 << PG_WRITE));

        // walk left waiting on its page entry while protected mode is switched on
        request(32'h0000_6000, KIND_DATA_READ);
        respond(32'h0070_0000);
        configure(32'hF, 32'h0000_1000, 32'h0000_0100, 32'h8000_0000,
                  (32'd1 << SEG_READ), 32'h0, 32'hFFFF_FFFF, 32'h1F);
        respond(32'h5555_5000 | (32'd1 << PG_VALID) | (32'd1 << PG_PROTECT) |
                (32'd1 << PG_READ));
        request(32'hDEAD_BEEF, KIND_CODE);
        request(32'h0000_7000, KIND_DATA_READ);
        request(32'h0000_8000, KIND_STACK_READ);

        goal      = predicted + RANDOM_ITEMS;
        phase_idx = 0;
        while (predicted < goal)
        begin
            random_settings(phase_idx);
            gaps_on     = ($urandom_range(0, 3) != 0);
            sink_stalls = ($urandom_range(0, 3) != 0);
            if (phase_idx == 3)
            begin
                gaps_on  = 1'b0;
                hold_req = 1'b1;
            end
            phase_goal = predicted + $urandom_range(60, 220);
            while (predicted < phase_goal && predicted < goal)
            begin
                if ($urandom_range(0, 99) < 82)
                    walk_sequence();
                else
                    send(1'($urandom_range(0, 1)), $urandom, 3'($urandom_range(0, 7)),
                         $urandom);
            end
            phase_idx++;
        end

        drain();
        if (failures == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial
    begin
        #(TIMEOUT_NS);
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

// ----- segment_page_translation_walker.f -----
hdl/sptw_pkg.sv
hdl/segment_page_translation_walker.sv
hdl/sptw_checker.sv
tb/translation_checker.sv
tb/tb_segment_page_translation_walker.sv
